### design/spc_pkg.sv
// spc_pkg: shared types and codes for the stepper position controller.
// No dependencies; used by spc_step, stepper_position_controller_top and the benches.
package spc_pkg;

  // Command codes carried in s_tuser
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_TARGET = 2'd1;
  localparam logic [1:0] OP_HOME   = 2'd2;

  localparam logic [14:0] START_MAX_RESET = 15'd2048;

  // Wave-drive coil patterns
  localparam logic [3:0] COIL_A = 4'h1;
  localparam logic [3:0] COIL_D = 4'h8;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_HOME_SEEK,
    MODE_HOME_BACK,
    MODE_LEARN_SEEK,
    MODE_LEARN_BACK
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_REACHED,
    EV_UPPER,
    EV_LOWER,
    EV_HOMED,
    EV_LEARNED
  } ev_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] target;
    logic               endpoint;
    logic               force_req;
  } item_t;

  // Control state shared between the step logic and the state registers
  typedef struct packed {
    mode_t       mode;
    logic [3:0]  phase;
    logic        learned_valid;
    logic [14:0] learned_max;
  } ctrl_t;

  typedef struct packed {
    logic [3:0]         coils;
    logic               slow;
    logic signed [15:0] position;
    ev_t                event_res;
    logic               endpoint_zeroed;
    logic               busy_res;
    logic [14:0]        max_limit;
  } res_t;

endpackage

### design/stepper_position_controller_top.sv
// Stepper position controller, top level: stream ports, state registers,
// input and result stages. Depends on spc_pkg and spc_step.
//
// An accepted transaction is held in the input register, then in the result
// register, which offers it on the result stream.
// Throughput: one transaction per cycle while m_tready is high; the step logic
// sits between the two registers, and state updates as the item advances.
// Reset (rst, synchronous, active high): pos 0, goal 0, coil A, idle,
// no learned limit, start_max_step 2048, both stages empty.
module stepper_position_controller_top #(
  parameter int POS_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // target[15:0], endpoint[16], force_req[17], zero pad
  input  logic [1:0]  s_tuser,   // op[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // coils[3:0], slow[4], position[20:5],
                                 // event_res[23:21], endpoint_zeroed[24],
                                 // busy_res[25], max_limit[40:26], zero pad
  // configuration: start_max_step
  input  logic        cfg_wen,
  input  logic [14:0] cfg_wdata
);

  // input stage
  logic           in_valid;
  spc_pkg::item_t in_item;
  // result stage
  logic           res_valid;
  spc_pkg::res_t  res;

  // controller state
  spc_pkg::ctrl_t              ctrl, ctrl_next;
  logic signed [POS_WIDTH-1:0] pos, pos_next;
  logic signed [POS_WIDTH-1:0] goal, goal_next;
  logic [14:0]                 start_max;
  spc_pkg::res_t               step_res;

  logic advance;

  // item moves into the result stage when that stage is free or draining
  assign advance  = in_valid && (!res_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op        <= s_tuser;
      in_item.target    <= $signed(s_tdata[15:0]);
      in_item.endpoint  <= s_tdata[16];
      in_item.force_req <= s_tdata[17];
    end
  end

  spc_step #(
    .POS_WIDTH (POS_WIDTH)
  ) u_step (
    .item      (in_item),
    .ctrl      (ctrl),
    .pos       (pos),
    .goal      (goal),
    .start_max (start_max),
    .ctrl_next (ctrl_next),
    .pos_next  (pos_next),
    .goal_next (goal_next),
    .res       (step_res)
  );

  // state commits only when the transaction leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pos                <= '0;
      goal               <= '0;
      ctrl.mode          <= spc_pkg::MODE_IDLE;
      ctrl.phase         <= spc_pkg::COIL_A;
      ctrl.learned_valid <= 1'b0;
      ctrl.learned_max   <= '0;
    end else if (advance) begin
      pos  <= pos_next;
      goal <= goal_next;
      ctrl <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_max <= spc_pkg::START_MAX_RESET;
    end else if (cfg_wen) begin
      start_max <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {7'd0, res.max_limit, res.busy_res, res.endpoint_zeroed,
                     res.event_res, res.position, res.slow, res.coils};

  // wave drive keeps exactly one coil selected
  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(ctrl.phase))
    else $error("coil phase lost its one-hot pattern");

  a_coils_onehot0: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0(res.coils))
    else $error("result coil pattern not one-hot or zero");

  a_slow_has_step: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.slow) |-> (res.coils != 4'd0))
    else $error("slow pulse flagged without a step");

  a_zeroed_lower: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.endpoint_zeroed) |->
      (res.position == 16'sd0 && res.event_res == spc_pkg::EV_LOWER))
    else $error("endpoint zeroing without lower stop at zero");

  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("advanced transaction did not reach the result stage");

endmodule

### design/spc_step.sv
// spc_step: next-state and result logic for one transaction.
// Depends on spc_pkg. Purely combinational; registers live in the top level.
module spc_step #(
  parameter int POS_WIDTH = 16
) (
  input  spc_pkg::item_t                item,
  input  spc_pkg::ctrl_t                ctrl,
  input  logic signed [POS_WIDTH-1:0]   pos,
  input  logic signed [POS_WIDTH-1:0]   goal,
  input  logic [14:0]                   start_max,
  output spc_pkg::ctrl_t                ctrl_next,
  output logic signed [POS_WIDTH-1:0]   pos_next,
  output logic signed [POS_WIDTH-1:0]   goal_next,
  output spc_pkg::res_t                 res
);

  // compare width: holds both the position range and the 16-bit fields
  localparam int CW = ((POS_WIDTH > 16) ? POS_WIDTH : 16) + 1;
  localparam logic signed [POS_WIDTH-1:0] PMAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] PMIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

  function automatic logic [3:0] phase_up(input logic [3:0] p);
    logic [4:0] t;
    t = {p, 1'b0};
    return ((t > 5'd8) || (t == 5'd0)) ? spc_pkg::COIL_A : t[3:0];
  endfunction

  function automatic logic [3:0] phase_dn(input logic [3:0] p);
    logic [3:0] t;
    t = p >> 1;
    return (t == 4'd0) ? spc_pkg::COIL_D : t;
  endfunction

  logic signed [CW-1:0]        pmax_x, pmin_x, tgt_x, lim_x, half_x;
  logic signed [CW-1:0]        inc_x, dec_x, pos_n_x;
  logic signed [POS_WIDTH-1:0] goal_clamped, pos_inc, pos_dec;
  logic [14:0]                 lim, learn_val;
  logic [3:0]                  ph_up, ph_dn;
  logic                        up;

  assign pmax_x = CW'(PMAX);
  assign pmin_x = CW'(PMIN);
  assign tgt_x  = CW'(item.target);
  assign goal_clamped = (tgt_x > pmax_x) ? PMAX :
                        (tgt_x < pmin_x) ? PMIN : tgt_x[POS_WIDTH-1:0];

  assign lim    = ctrl.learned_valid ? ctrl.learned_max : start_max;
  assign lim_x  = CW'($signed({1'b0, lim}));
  assign half_x = CW'($signed({2'b00, lim[14:1]}));

  // saturating single steps
  assign pos_inc = (pos == PMAX) ? pos : pos + POS_WIDTH'(1);
  assign pos_dec = (pos == PMIN) ? pos : pos - POS_WIDTH'(1);
  assign inc_x   = CW'(pos_inc);
  assign dec_x   = CW'(pos_dec);
  assign ph_up   = phase_up(ctrl.phase);
  assign ph_dn   = phase_dn(ctrl.phase);
  assign up      = goal > pos;

  // learned limit: the position after the back-off step, clamped to 15 bits
  assign learn_val = (dec_x < 0) ? 15'd0 :
                     (dec_x > CW'(32767)) ? 15'h7FFF : dec_x[14:0];

  always_comb begin
    ctrl_next         = ctrl;
    pos_next          = pos;
    goal_next         = goal;
    res.coils           = 4'd0;
    res.slow            = 1'b0;
    res.event_res       = spc_pkg::EV_NONE;
    res.endpoint_zeroed = 1'b0;
    case (item.op)
      spc_pkg::OP_TARGET: begin
        goal_next = goal_clamped;
      end
      spc_pkg::OP_HOME: begin
        ctrl_next.mode = spc_pkg::MODE_HOME_SEEK;
      end
      spc_pkg::OP_TICK: begin
        case (ctrl.mode)
          spc_pkg::MODE_HOME_SEEK: begin
            if (!item.endpoint) begin
              pos_next = pos_dec;
              ctrl_next.phase = ph_dn;
              res.coils = ph_dn;
            end else begin
              pos_next = pos_inc;
              ctrl_next.phase = ph_up;
              res.coils = ph_up;
              res.slow = 1'b1;
              ctrl_next.mode = spc_pkg::MODE_HOME_BACK;
            end
          end
          spc_pkg::MODE_HOME_BACK: begin
            ctrl_next.phase = ph_up;
            res.coils = ph_up;
            if (item.endpoint) begin
              pos_next = pos_inc;
              res.slow = 1'b1;
            end else begin
              pos_next  = '0;
              goal_next = '0;
              res.event_res = spc_pkg::EV_HOMED;
              ctrl_next.mode = spc_pkg::MODE_IDLE;
            end
          end
          spc_pkg::MODE_LEARN_SEEK: begin
            if (!item.endpoint) begin
              pos_next = pos_inc;
              ctrl_next.phase = ph_up;
              res.coils = ph_up;
            end else begin
              pos_next = pos_dec;
              ctrl_next.phase = ph_dn;
              res.coils = ph_dn;
              ctrl_next.mode = spc_pkg::MODE_LEARN_BACK;
            end
          end
          spc_pkg::MODE_LEARN_BACK: begin
            pos_next = pos_dec;
            ctrl_next.phase = ph_dn;
            res.coils = ph_dn;
            if (!item.endpoint) begin
              ctrl_next.learned_max   = learn_val;
              ctrl_next.learned_valid = 1'b1;
              res.event_res = spc_pkg::EV_LEARNED;
              ctrl_next.mode = spc_pkg::MODE_IDLE;
            end
          end
          spc_pkg::MODE_IDLE: begin
            if (pos != goal) begin
              if (up) begin
                if (!item.force_req && (CW'(pos) >= lim_x)) begin
                  res.event_res = spc_pkg::EV_UPPER;
                end else begin
                  pos_next = pos_inc;
                  ctrl_next.phase = ph_up;
                  res.coils = ph_up;
                  if ((inc_x > half_x) && item.endpoint)
                    ctrl_next.mode = spc_pkg::MODE_LEARN_SEEK;
                  if (pos_inc == goal) res.event_res = spc_pkg::EV_REACHED;
                end
              end else if (!item.force_req && item.endpoint) begin
                // switch pressed while heading down: re-zero and stop
                pos_next = '0;
                res.endpoint_zeroed = 1'b1;
                res.event_res = spc_pkg::EV_LOWER;
              end else if (!item.force_req && (pos == '0)) begin
                res.event_res = spc_pkg::EV_LOWER;
              end else begin
                pos_next = pos_dec;
                ctrl_next.phase = ph_dn;
                res.coils = ph_dn;
                if (pos_dec == goal) res.event_res = spc_pkg::EV_REACHED;
              end
            end
          end
          default: begin
            ctrl_next.mode = spc_pkg::MODE_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase
    pos_n_x       = CW'(pos_next);
    res.position  = pos_n_x[15:0];
    res.busy_res  = (ctrl_next.mode != spc_pkg::MODE_IDLE);
    res.max_limit = ctrl_next.learned_valid ? ctrl_next.learned_max : start_max;
  end

endmodule

### verif/spc_move_checker.sv
`timescale 1ns / 100ps
// spc_move_checker: watches the stream and configuration ports of the stepper
// position controller, predicts every result and compares it field by field.
// Depends on spc_pkg for command codes, modes, events and the result layout.
module spc_move_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        cfg_wen,
  input  logic [14:0] cfg_wdata,
  output int          fail_count,
  output int          outstanding
);

  // motor state as the block should hold it
  logic signed [15:0] pos_q;
  logic signed [15:0] goal_q;
  logic [3:0]         phase_q;
  spc_pkg::mode_t     mode_q;
  logic [14:0]        learned_q;
  logic               learned_ok_q;
  logic [14:0]        start_max_q;

  spc_pkg::res_t      expected_moves[$];
  spc_pkg::res_t      want;

  function automatic logic [14:0] limit_in_force();
    return learned_ok_q ? learned_q : start_max_q;
  endfunction

  // one wave-drive step with saturating position; returns the coil pattern
  function automatic logic [3:0] wave_step(input logic up);
    logic [4:0] ph;
    int         p;
    p = pos_q;
    if (up) begin
      ph = {phase_q, 1'b0};
      if (ph > 5'(spc_pkg::COIL_D) || ph == 5'd0) ph = 5'(spc_pkg::COIL_A);
      p++;
    end else begin
      ph = {1'b0, phase_q} >> 1;
      if (ph == 5'd0 || ph > 5'(spc_pkg::COIL_D)) ph = 5'(spc_pkg::COIL_D);
      p--;
    end
    phase_q = ph[3:0];
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    pos_q = 16'(p);
    return phase_q;
  endfunction

  function automatic spc_pkg::res_t predict_move(input logic [1:0] op,
                                                 input logic signed [15:0] tgt,
                                                 input logic ep, input logic frc);
    spc_pkg::res_t r;
    int   lim;
    logic up;
    logic blocked;
    r = '0;
    case (op)
      spc_pkg::OP_TARGET: goal_q = tgt;
      spc_pkg::OP_HOME:   mode_q = spc_pkg::MODE_HOME_SEEK;
      spc_pkg::OP_TICK: begin
        case (mode_q)
          spc_pkg::MODE_HOME_SEEK: begin
            // down until the switch closes, then the first slow step back
            r.coils = wave_step(ep);
            if (ep) begin
              r.slow = 1'b1;
              mode_q = spc_pkg::MODE_HOME_BACK;
            end
          end
          spc_pkg::MODE_HOME_BACK: begin
            r.coils = wave_step(1'b1);
            if (ep) begin
              r.slow = 1'b1;
            end else begin
              pos_q = '0;
              goal_q = '0;
              r.event_res = spc_pkg::EV_HOMED;
              mode_q = spc_pkg::MODE_IDLE;
            end
          end
          spc_pkg::MODE_LEARN_SEEK: begin
            r.coils = wave_step(!ep);
            if (ep) mode_q = spc_pkg::MODE_LEARN_BACK;
          end
          spc_pkg::MODE_LEARN_BACK: begin
            r.coils = wave_step(1'b0);
            if (!ep) begin
              learned_q = (pos_q < 0) ? 15'd0 : pos_q[14:0];
              learned_ok_q = 1'b1;
              r.event_res = spc_pkg::EV_LEARNED;
              mode_q = spc_pkg::MODE_IDLE;
            end
          end
          spc_pkg::MODE_IDLE: begin
            if (pos_q != goal_q) begin
              up = goal_q > pos_q;
              lim = limit_in_force();
              blocked = 1'b0;
              if (!frc) begin
                if (up) begin
                  if (pos_q >= lim) begin
                    r.event_res = spc_pkg::EV_UPPER;
                    blocked = 1'b1;
                  end
                end else begin
                  if (ep) begin
                    pos_q = '0;
                    r.endpoint_zeroed = 1'b1;
                  end
                  if (pos_q == 0) begin
                    r.event_res = spc_pkg::EV_LOWER;
                    blocked = 1'b1;
                  end
                end
              end
              if (!blocked) begin
                r.coils = wave_step(up);
                if (up && pos_q > lim / 2 && ep) mode_q = spc_pkg::MODE_LEARN_SEEK;
                if (pos_q == goal_q) r.event_res = spc_pkg::EV_REACHED;
              end
            end
          end
          default: mode_q = spc_pkg::MODE_IDLE;
        endcase
      end
      default: ;
    endcase
    r.position = pos_q;
    r.busy_res = (mode_q != spc_pkg::MODE_IDLE);
    r.max_limit = limit_in_force();
    return r;
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pos_q = '0;
      goal_q = '0;
      phase_q = spc_pkg::COIL_A;
      mode_q = spc_pkg::MODE_IDLE;
      learned_q = '0;
      learned_ok_q = 1'b0;
      start_max_q = spc_pkg::START_MAX_RESET;
      expected_moves.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (cfg_wen) start_max_q = cfg_wdata;
      // results leave only after passing both stages, so compare before predicting
      if (m_tvalid && m_tready) begin
        if (expected_moves.size() == 0) begin
          $error("result transaction with no prediction waiting");
          fail_count++;
        end else begin
          want = expected_moves.pop_front();
          check_field("coils", want.coils, m_tdata[3:0]);
          check_field("slow", want.slow, m_tdata[4]);
          check_field("position", want.position, $signed(m_tdata[20:5]));
          check_field("event_res", want.event_res, m_tdata[23:21]);
          check_field("endpoint_zeroed", want.endpoint_zeroed, m_tdata[24]);
          check_field("busy_res", want.busy_res, m_tdata[25]);
          check_field("max_limit", want.max_limit, m_tdata[40:26]);
        end
      end
      if (s_tvalid && s_tready)
        expected_moves.push_back(predict_move(s_tuser, s_tdata[15:0], s_tdata[16],
                                              s_tdata[17]));
      outstanding <= expected_moves.size();
    end
  end

endmodule

### verif/tb_stepper_position_controller_top.sv
`timescale 1ns / 100ps
// tb_stepper_position_controller_top: stimulus and verdict for the stepper
// position controller. Depends on spc_pkg, the block and spc_move_checker.
module tb_stepper_position_controller_top;

  // op code the block does not use; it must act as a no-op
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 20000;
  // one long receiver hold-off so the two stages fill and s_tready drops
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned HOLD_LEN    = 120;
  // window with no idling on either side
  localparam int unsigned QUIET_FROM  = 600;
  localparam int unsigned QUIET_TO    = 800;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_wen   = 1'b0;
  logic [14:0] cfg_wdata = '0;

  int          fail_count;
  int          outstanding;
  int unsigned cycle_count = 0;
  int unsigned hold_left   = 0;
  int          items_sent  = 0;
  logic        quiet;

  assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

  always #6 clk = ~clk;

  stepper_position_controller_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  spc_move_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_stepper_position_controller_top: FAIL");
      $finish;
    end
  end

  // receiver: random back-pressure, plus one long hold-off counted here
  always @(posedge clk) begin
    if (cycle_count == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 12);
    end
  end

  // One input transaction. s_tready is read right after the edge, so it is
  // the value that decided acceptance at that edge.
  task automatic send_item(input logic [1:0] op, input logic [15:0] tgt,
                           input logic ep, input logic frc);
    while (!quiet && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'd0, frc, ep, tgt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // target field is don't-care on a tick; random keeps every bit moving
  task automatic tick(input logic ep, input logic frc);
    send_item(spc_pkg::OP_TICK, 16'($urandom), ep, frc);
  endtask

  function automatic logic frc_bit(input bit allow_force);
    return allow_force && ($urandom_range(1) == 1);
  endfunction

  // mostly near zero so moves finish; now and then anything in range
  function automatic logic [15:0] pick_target();
    if ($urandom_range(7) == 0) return 16'($urandom);
    return 16'($urandom_range(40)) - 16'd20;
  endfunction

  // stop offering and wait until every predicted result has been seen;
  // outstanding is registered, hence the first wait
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // every item makes a result, so an empty pipe means the block is idle
  task automatic write_limit(input logic [14:0] value);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // shortest homing: switch already closed, one back-off step, release
  task automatic go_home();
    send_item(spc_pkg::OP_HOME, 16'($urandom), 1'b0, 1'b0);
    tick(1'b1, 1'b0);
    tick(1'b0, 1'b0);
  endtask

  // Random phase built from well-formed homing, move and learn sequences,
  // with some raw noise. allow_learn enables the directed learn sequences, kept
  // off while the start_max register still matters.
  task automatic random_phase(input int n, input bit allow_force, input bit allow_learn);
    int stop_at;
    int kind;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 20) begin
        send_item(spc_pkg::OP_HOME, 16'($urandom), 1'($urandom_range(1)),
                  frc_bit(allow_force));
        repeat ($urandom_range(4)) tick(1'b0, frc_bit(allow_force));
        if ($urandom_range(3) == 0)
          send_item(spc_pkg::OP_HOME, 16'($urandom), 1'b0, frc_bit(allow_force));
        if ($urandom_range(3) == 0)
          send_item(spc_pkg::OP_TARGET, pick_target(), 1'($urandom_range(1)),
                    frc_bit(allow_force));
        repeat ($urandom_range(1, 3)) tick(1'b1, frc_bit(allow_force));
        tick(1'b0, frc_bit(allow_force));
      end else if (kind < 40 && allow_learn) begin
        // climb, hit the switch, overshoot a little, back off with the switch held
        send_item(spc_pkg::OP_TARGET, 16'($urandom_range(1, 30)), 1'b0, 1'b0);
        repeat ($urandom_range(2, 10)) tick(1'b0, frc_bit(allow_force));
        tick(1'b1, frc_bit(allow_force));
        repeat ($urandom_range(3)) tick(1'b0, frc_bit(allow_force));
        tick(1'b1, frc_bit(allow_force));
        repeat ($urandom_range(12)) tick(1'b1, frc_bit(allow_force));
        tick(1'b0, frc_bit(allow_force));
      end else if (kind < 85) begin
        send_item(spc_pkg::OP_TARGET, pick_target(), 1'($urandom_range(1)),
                  frc_bit(allow_force));
        repeat ($urandom_range(1, 12)) tick($urandom_range(99) < 15, frc_bit(allow_force));
      end else begin
        send_item(2'($urandom_range(3)), 16'($urandom), 1'($urandom_range(1)),
                  frc_bit(allow_force));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, reset limit 2048
    tick(1'b0, 1'b0);                                      // at the goal: nothing moves
    send_item(OP_SPARE, 16'hFFFF, 1'b1, 1'b1);             // unused op, all ones
    send_item(spc_pkg::OP_TARGET, 16'h7FFF, 1'b0, 1'b0);   // largest target
    tick(1'b0, 1'b0);
    tick(1'b0, 1'b0);
    tick(1'b1, 1'b1);                                      // forced, switch seen going up
    send_item(spc_pkg::OP_TARGET, 16'h8000, 1'b0, 1'b0);   // smallest target
    tick(1'b0, 1'b0);
    tick(1'b1, 1'b0);                                      // switch zeroes, lower stop
    tick(1'b0, 1'b0);                                      // stuck at zero
    tick(1'b0, 1'b1);                                      // forced below zero
    send_item(spc_pkg::OP_TARGET, 16'h0000, 1'b0, 1'b0);
    tick(1'b0, 1'b0);                                      // back to zero: reached
    send_item(spc_pkg::OP_HOME, 16'h0000, 1'b0, 1'b0);
    tick(1'b0, 1'b0);                                      // seeking down
    send_item(spc_pkg::OP_HOME, 16'h0000, 1'b0, 1'b0);     // restart mid-seek
    send_item(spc_pkg::OP_TARGET, 16'd7, 1'b0, 1'b0);      // goal change mid-sequence
    tick(1'b1, 1'b0);                                      // switch: slow back-off
    tick(1'b1, 1'b1);                                      // still held; force ignored
    tick(1'b0, 1'b0);                                      // released: homed
    tick(1'b0, 1'b0);

    // limit 0: no forcing, so no move to a goal can climb above zero
    write_limit(15'd0);
    go_home();
    random_phase(100, 1'b0, 1'b0);

    // limit at its top
    write_limit(15'h7FFF);
    go_home();
    random_phase(100, 1'b1, 1'b0);

    write_limit(15'd500);
    go_home();
    random_phase(130, 1'b1, 1'b0);

    // small limit, last setting: learn sequences allowed from here on
    write_limit(15'd8);
    go_home();
    random_phase(220, 1'b1, 1'b1);

    go_home();
    random_phase(100, 1'b1, 1'b1);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_stepper_position_controller_top: PASS");
    end else begin
      $display("tb_stepper_position_controller_top: FAIL");
    end
    $finish;
  end

endmodule

### stepper_position_controller_top.f
design/spc_pkg.sv
design/spc_step.sv
design/stepper_position_controller_top.sv
verif/spc_move_checker.sv
verif/tb_stepper_position_controller_top.sv
